// File: design/sra_pkg.sv
// shared types, constants and register codes of the selective-repeat sender
`default_nettype none

package sra_pkg;

  // default sizing
  localparam int SEQ_SPACE_DEF  = 64;
  localparam int MAX_WINDOW_DEF = 16;
  localparam int STAMP_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int WIN_SIZE_W = 5;
  localparam int TIMEOUT_W  = 8;
  localparam int PKT_CNT_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT   = 2'd2;

  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RST = 5'd4;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 8'd3;
  localparam logic [PKT_CNT_W-1:0]  PKT_CNT_RST  = 7'd10;

  typedef struct packed {
    logic [WIN_SIZE_W-1:0] win_size;
    logic [TIMEOUT_W-1:0]  timeout_ticks;
    logic [PKT_CNT_W-1:0]  packet_count;
  } cfg_t;

  // result control from the sequencer to the output stage
  typedef struct packed {
    logic push;
    logic fin;
    logic is_resend;
    logic all_done;
  } res_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SL_RD,
    ST_SL_CHK,
    ST_START,
    ST_SCAN,
    ST_SEND,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// File: design/sra_if.sv
// valid/ready channel interfaces for events in and transmissions out
`default_nettype none

interface sra_in_if #(
  parameter int SEQ_W = $clog2(sra_pkg::SEQ_SPACE_DEF)
);
  logic             valid;
  logic             ready;
  logic             mode;
  logic [SEQ_W-1:0] ack_seq;

  modport source (output valid, output mode, output ack_seq, input ready);
  modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

interface sra_out_if #(
  parameter int SEQ_W = $clog2(sra_pkg::SEQ_SPACE_DEF)
);
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] send_seq;
  logic             is_resend;
  logic             last;
  logic             all_done;

  modport source (output valid, output send_seq, output is_resend, output last,
                  output all_done, input ready);
  modport sink   (input valid, input send_seq, input is_resend, input last,
                  input all_done, output ready);
endinterface

`default_nettype wire

// File: design/sra_outq.sv
// output stage: one held-back item to find the last of a step, then the output register
`default_nettype none

module sra_outq #(
  parameter int SEQ_W = $clog2(sra_pkg::SEQ_SPACE_DEF)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sra_pkg::res_ctl_t ctl_i,
  input  logic [SEQ_W-1:0]  seq_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic              out_resend_o,
  output logic              out_last_o,
  output logic              out_done_o
);
  import sra_pkg::*;

  logic             pend_v_q, pend_v_d;
  logic [SEQ_W-1:0] pend_seq_q;
  logic             pend_rs_q, pend_dn_q;
  logic             out_v_q, out_v_d;
  logic [SEQ_W-1:0] out_seq_q;
  logic             out_rs_q, out_last_q, out_dn_q;
  logic             out_free;
  logic             move;

  assign out_free = !out_v_q || out_ready_i;
  assign room_o   = !pend_v_q || out_free;
  // the held item goes out once the next one arrives or the step ends, if the output register is free
  assign move     = pend_v_q && out_free && (ctl_i.push || ctl_i.fin);

  always_comb begin
    out_v_d  = out_v_q;
    pend_v_d = pend_v_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (move) begin
      out_v_d = 1'b1;
    end
    if (ctl_i.push) begin
      pend_v_d = 1'b1;
    end else if (move) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_seq_q  <= pend_seq_q;
      out_rs_q   <= pend_rs_q;
      out_dn_q   <= pend_dn_q;
      out_last_q <= ctl_i.fin;
    end
    if (ctl_i.push) begin
      pend_seq_q <= seq_i;
      pend_rs_q  <= ctl_i.is_resend;
      pend_dn_q  <= ctl_i.all_done;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_seq_o    = out_seq_q;
  assign out_resend_o = out_rs_q;
  assign out_last_o   = out_last_q;
  assign out_done_o   = out_dn_q;

endmodule

`default_nettype wire

// File: design/sra_core.sv
// sequencer and per-packet state memory: ack marking, base slide, resend and send scans
`default_nettype none

module sra_core #(
  parameter int SEQ_SPACE  = sra_pkg::SEQ_SPACE_DEF,
  parameter int MAX_WINDOW = sra_pkg::MAX_WINDOW_DEF,
  parameter int STAMP_BITS = sra_pkg::STAMP_BITS_DEF,
  parameter int SEQ_W      = $clog2(SEQ_SPACE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sra_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  logic [SEQ_W-1:0]  in_ack_i,
  output sra_pkg::res_ctl_t ctl_o,
  output logic [SEQ_W-1:0]  seq_o,
  input  logic              room_i
);
  import sra_pkg::*;

  localparam int CNT_W   = $clog2(SEQ_SPACE + 1);
  localparam int EW      = $clog2(SEQ_SPACE + MAX_WINDOW + 1);
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int OFS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MW      = STAMP_BITS + 2;
  localparam int ACK_BIT = MW - 1;
  localparam int TMR_BIT = MW - 2;

  // entry word: acked, timer running, send stamp
  logic [MW-1:0] mem_q [SEQ_SPACE];
  logic [MW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [SEQ_W-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  state_e state_q, state_d;
  logic [SEQ_W-1:0]      clr_q, clr_d;
  logic [CNT_W-1:0]      base_q, base_d;
  logic [STAMP_BITS-1:0] tick_q, tick_d;
  logic [EW-1:0]         end_q, end_d;
  logic                  done_q, done_d;
  logic [MAX_WINDOW-1:0] mask_q, mask_d;
  logic [EW-1:0]         ridx_q, ridx_d;
  logic                  cv_q, cv_d;
  logic [SEQ_W-1:0]      cidx_q, cidx_d;
  logic [WW-1:0]         ofs_q, ofs_d;

  logic [CNT_W-1:0]      cnt_eff;
  logic [WW-1:0]         win_eff;
  logic [EW-1:0]         win_end;
  logic [EW-1:0]         ofs_sub;
  logic [EW-1:0]         send_pos;
  logic [STAMP_BITS-1:0] age;
  logic                  hit, fresh;

  always_comb begin
    if (32'(cfg_i.packet_count) > 32'(SEQ_SPACE)) begin
      cnt_eff = CNT_W'(SEQ_SPACE);
    end else begin
      cnt_eff = CNT_W'(cfg_i.packet_count);
    end
    if (cfg_i.win_size == '0) begin
      win_eff = WW'(1);
    end else if (32'(cfg_i.win_size) > 32'(MAX_WINDOW)) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(cfg_i.win_size);
    end
  end

  assign win_end  = EW'(base_q) + EW'(win_eff);
  assign ofs_sub  = EW'(cidx_q) - EW'(base_q);
  assign send_pos = EW'(base_q) + EW'(ofs_q);
  assign age      = tick_q - rdata_q[STAMP_BITS-1:0];
  assign hit      = cv_q && rdata_q[TMR_BIT] && (age >= STAMP_BITS'(cfg_i.timeout_ticks));
  assign fresh    = cv_q && !rdata_q[ACK_BIT] && !rdata_q[TMR_BIT];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    base_d     = base_q;
    tick_d     = tick_q;
    end_d      = end_q;
    done_d     = done_q;
    mask_d     = mask_q;
    ridx_d     = ridx_q;
    cv_d       = cv_q;
    cidx_d     = cidx_q;
    ofs_d      = ofs_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.all_done = done_q;
    seq_o      = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == SEQ_W'(SEQ_SPACE - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_START;
          if (in_mode_i) begin
            if (CNT_W'(in_ack_i) < cnt_eff) begin
              mem_we    = 1'b1;
              mem_waddr = in_ack_i;
              mem_wdata = {1'b1, 1'b0, STAMP_BITS'(0)};
              state_d   = ST_SL_RD;
            end
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end
      end

      ST_SL_RD: begin
        if (base_q < cnt_eff) begin
          mem_re    = 1'b1;
          mem_raddr = base_q[SEQ_W-1:0];
          state_d   = ST_SL_CHK;
        end else begin
          state_d = ST_START;
        end
      end

      ST_SL_CHK: begin
        if (rdata_q[ACK_BIT]) begin
          base_d  = base_q + 1'b1;
          state_d = ST_SL_RD;
        end else begin
          state_d = ST_START;
        end
      end

      ST_START: begin
        end_d   = (win_end < EW'(cnt_eff)) ? win_end : EW'(cnt_eff);
        done_d  = (base_q >= cnt_eff);
        mask_d  = '0;
        ridx_d  = EW'(base_q);
        cv_d    = 1'b0;
        state_d = ST_SCAN;
      end

      // resend pass: read one entry ahead while the previous one is checked
      ST_SCAN: begin
        if (!(hit && !room_i)) begin
          if (cv_q) begin
            mask_d[ofs_sub[OFS_W-1:0]] = fresh;
            if (hit) begin
              ctl_o.push      = 1'b1;
              ctl_o.is_resend = 1'b1;
              seq_o           = cidx_q;
              mem_we          = 1'b1;
              mem_waddr       = cidx_q;
              mem_wdata       = {1'b0, 1'b1, tick_q};
            end
          end
          if (ridx_q < end_q) begin
            mem_re    = 1'b1;
            mem_raddr = ridx_q[SEQ_W-1:0];
            cv_d      = 1'b1;
            cidx_d    = ridx_q[SEQ_W-1:0];
            ridx_d    = ridx_q + 1'b1;
          end else begin
            cv_d = 1'b0;
            if (!cv_q) begin
              ofs_d   = '0;
              state_d = ST_SEND;
            end
          end
        end
      end

      // new-send pass over the marks taken during the resend pass
      ST_SEND: begin
        seq_o = send_pos[SEQ_W-1:0];
        if (send_pos < end_q) begin
          if (mask_q[ofs_q[OFS_W-1:0]]) begin
            if (room_i) begin
              ctl_o.push = 1'b1;
              mem_we     = 1'b1;
              mem_waddr  = send_pos[SEQ_W-1:0];
              mem_wdata  = {1'b0, 1'b1, tick_q};
              ofs_d      = ofs_q + 1'b1;
            end
          end else begin
            ofs_d = ofs_q + 1'b1;
          end
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        ctl_o.fin = 1'b1;
        if (room_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      base_q  <= '0;
      tick_q  <= '0;
      end_q   <= '0;
      done_q  <= 1'b0;
      mask_q  <= '0;
      ridx_q  <= '0;
      cv_q    <= 1'b0;
      cidx_q  <= '0;
      ofs_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      base_q  <= base_d;
      tick_q  <= tick_d;
      end_q   <= end_d;
      done_q  <= done_d;
      mask_q  <= mask_d;
      ridx_q  <= ridx_d;
      cv_q    <= cv_d;
      cidx_q  <= cidx_d;
      ofs_q   <= ofs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/selective_repeat_arq_sender_top.sv
// top level of the selective-repeat sender: config registers, sequencer, output stage
//
//   channel  dir  handshake             carries
//   in_i     in   valid/ready           mode, ack_seq
//   out_o    out  valid/ready           send_seq, is_resend, last, all_done
//   cfg      in   cfg_we_i (no wait)    cfg_idx_i, cfg_wdata_i
//
// after reset the state memory is cleared, one entry a cycle; no item is taken meanwhile,
// config writes are; an item is taken only in idle: a tick advances the tick count, an
// acknowledgement in range is marked and the base slides over acknowledged slots, then a
// resend scan and a new-send scan run over the window, made non-empty and cut at the packet
// count, before the next item is taken; the single read port of the state memory sets the scan rate
// a stalled output holds the scans; the next item is taken while the last result waits
`default_nettype none

module selective_repeat_arq_sender_top #(
  parameter int SEQ_SPACE  = sra_pkg::SEQ_SPACE_DEF,
  parameter int MAX_WINDOW = sra_pkg::MAX_WINDOW_DEF,
  parameter int STAMP_BITS = sra_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sra_in_if.sink                         in_i,
  sra_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [sra_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sra_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sra_pkg::*;

  localparam int SEQ_W = $clog2(SEQ_SPACE);

  cfg_t             cfg_q, cfg_d;
  res_ctl_t         ctl;
  logic [SEQ_W-1:0] res_seq;
  logic             room;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WINDOW:  cfg_d.win_size      = cfg_wdata_i[WIN_SIZE_W-1:0];
        CFG_IDX_TIMEOUT: cfg_d.timeout_ticks = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_IDX_COUNT:   cfg_d.packet_count  = cfg_wdata_i[PKT_CNT_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_size      <= WIN_SIZE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.packet_count  <= PKT_CNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sra_core #(
    .SEQ_SPACE  (SEQ_SPACE),
    .MAX_WINDOW (MAX_WINDOW),
    .STAMP_BITS (STAMP_BITS),
    .SEQ_W      (SEQ_W)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_mode_i  (in_i.mode),
    .in_ack_i   (in_i.ack_seq),
    .ctl_o      (ctl),
    .seq_o      (res_seq),
    .room_i     (room)
  );

  sra_outq #(
    .SEQ_W (SEQ_W)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .seq_i        (res_seq),
    .room_o       (room),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_seq_o    (out_o.send_seq),
    .out_resend_o (out_o.is_resend),
    .out_last_o   (out_o.last),
    .out_done_o   (out_o.all_done)
  );

endmodule

`default_nettype wire

// File: design/sra_checker.sv
// port-level checks of the selective-repeat sender, bound to the top level
`default_nettype none

module sra_checker #(
  parameter int SEQ_W = $clog2(sra_pkg::SEQ_SPACE_DEF)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SEQ_W-1:0] out_seq_i,
  input logic             out_resend_i,
  input logic             out_last_i,
  input logic             out_done_i
);
  import sra_pkg::*;

  logic             prev_v_q;
  logic [SEQ_W-1:0] prev_seq_q;
  logic             prev_rs_q;
  logic             prev_dn_q;
  logic             seen_new_q;
  logic             out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  // what came before in the current step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_v_q   <= 1'b0;
      prev_seq_q <= '0;
      prev_rs_q  <= 1'b0;
      prev_dn_q  <= 1'b0;
      seen_new_q <= 1'b0;
    end else if (out_acc) begin
      if (out_last_i) begin
        prev_v_q   <= 1'b0;
        seen_new_q <= 1'b0;
      end else begin
        prev_v_q   <= 1'b1;
        prev_seq_q <= out_seq_i;
        prev_rs_q  <= out_resend_i;
        prev_dn_q  <= out_done_i;
        seen_new_q <= seen_new_q || !out_resend_i;
      end
    end
  end

  a_in_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  a_resends_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_new_q |-> !out_resend_i)
    else $error("resend after a new send in one step");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prev_v_q && (out_resend_i == prev_rs_q) |-> out_seq_i > prev_seq_q)
    else $error("sequence numbers not ascending within a group");

  a_done_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prev_v_q |-> out_done_i == prev_dn_q)
    else $error("all_done changed within a step");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seq_i) && $stable(out_last_i))
    else $error("stalled output item changed");

endmodule

bind selective_repeat_arq_sender_top sra_checker #(
  .SEQ_W (SEQ_W)
) u_sra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_seq_i    (out_o.send_seq),
  .out_resend_i (out_o.is_resend),
  .out_last_i   (out_o.last),
  .out_done_i   (out_o.all_done)
);

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench of the selective-repeat sender: mirrored state, directed and random items
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sra_pkg::*;

  localparam int SEQ_N         = SEQ_SPACE_DEF;
  localparam int WIN_MAX       = MAX_WINDOW_DEF;
  localparam int STAMP_W       = STAMP_BITS_DEF;
  localparam int SEQ_W         = $clog2(SEQ_N);
  localparam bit MODE_TICK     = 1'b0;
  localparam bit MODE_ACK      = 1'b1;
  localparam int IDLE_PCT      = 26;
  // longest item with no transmission: full window scan plus a slide over every slot
  localparam int SETTLE_CYCLES = 250;

  typedef struct packed {
    logic [SEQ_W-1:0] send_seq;
    logic             is_resend;
    logic             last;
    logic             all_done;
  } tx_t;

  class tx_ledger;
    logic [WIN_SIZE_W-1:0] win_reg;
    logic [TIMEOUT_W-1:0]  tmo_reg;
    logic [PKT_CNT_W-1:0]  cnt_reg;
    bit                    acked [SEQ_N];
    bit                    timing [SEQ_N];
    logic [STAMP_W-1:0]    stamp [SEQ_N];
    int unsigned           base;
    logic [STAMP_W-1:0]    tick;
    tx_t                   due [$];
    int unsigned           errors;

    function new();
      win_reg = WIN_SIZE_RST;
      tmo_reg = TIMEOUT_RST;
      cnt_reg = PKT_CNT_RST;
      foreach (acked[i]) begin
        acked[i]  = 1'b0;
        timing[i] = 1'b0;
        stamp[i]  = '0;
      end
      base   = 0;
      tick   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_WINDOW:  win_reg = data[WIN_SIZE_W-1:0];
        CFG_IDX_TIMEOUT: tmo_reg = data[TIMEOUT_W-1:0];
        CFG_IDX_COUNT:   cnt_reg = data[PKT_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pkt_limit();
      return (cnt_reg > SEQ_N) ? SEQ_N : cnt_reg;
    endfunction

    // one past the last slot of the window, cut at the packet count
    function int unsigned window_end();
      int unsigned w;
      int unsigned stop;
      w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
      stop = base + w;
      return (stop > pkt_limit()) ? pkt_limit() : stop;
    endfunction

    function void take_event(bit mode, logic [SEQ_W-1:0] ack);
      int unsigned        cnt;
      int unsigned        stop;
      int unsigned        i;
      logic               done;
      logic [STAMP_W-1:0] age;
      tx_t                batch [$];
      cnt = pkt_limit();
      if (mode == MODE_ACK) begin
        if (ack < cnt) begin
          acked[ack]  = 1'b1;
          timing[ack] = 1'b0;
          while (base < cnt && acked[base]) base++;
        end
      end else begin
        tick = tick + 1'b1;
      end
      done = (base >= cnt);
      stop = window_end();
      for (i = base; i < stop; i++) begin
        if (timing[i]) begin
          age = tick - stamp[i];
          if (age >= tmo_reg) begin
            batch.push_back({SEQ_W'(i), 1'b1, 1'b0, done});
            stamp[i] = tick;
          end
        end
      end
      for (i = base; i < stop; i++) begin
        if (!acked[i] && !timing[i]) begin
          batch.push_back({SEQ_W'(i), 1'b0, 1'b0, done});
          timing[i] = 1'b1;
          stamp[i]  = tick;
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) due.push_back(batch[k]);
    endfunction

    function void match_tx(tx_t got);
      tx_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: expected no transmission, actual seq %0d resend %0b last %0b done %0b",
                 $time, got.send_seq, got.is_resend, got.last, got.all_done);
        return;
      end
      want = due.pop_front();
      if (got.send_seq !== want.send_seq || got.is_resend !== want.is_resend ||
          got.last !== want.last || got.all_done !== want.all_done) begin
        errors++;
        $display("%0t: expected seq/resend/last/done %0d/%0b/%0b/%0b, actual %0d/%0b/%0b/%0b",
                 $time, want.send_seq, want.is_resend, want.last, want.all_done,
                 got.send_seq, got.is_resend, got.last, got.all_done);
      end
    endfunction

    // a sent, unacknowledged packet in the window, the lowest one half of the time
    function bit find_outstanding(inout logic [SEQ_W-1:0] seq);
      int unsigned cand [$];
      int unsigned i;
      int unsigned stop;
      stop = window_end();
      for (i = base; i < stop; i++) begin
        if (timing[i] && !acked[i]) cand.push_back(i);
      end
      if (cand.size() == 0) return 1'b0;
      if ($urandom_range(1) == 0) seq = SEQ_W'(cand[0]);
      else seq = SEQ_W'(cand[$urandom_range(cand.size()-1)]);
      return 1'b1;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    quiet;
  tx_ledger              sb;

  sra_in_if  in_ch ();
  sra_out_if out_ch ();

  selective_repeat_arq_sender_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.match_tx({out_ch.send_seq, out_ch.is_resend, out_ch.last, out_ch.all_done});
    end
  end

  task automatic send_event(bit mode, logic [SEQ_W-1:0] ack);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.ack_seq <= ack;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.take_event(mode, ack);
    @(negedge clk_i);
  endtask

  // hold the input until every transmission has come out and the block has gone quiet
  task automatic settle_out();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] tmo,
                            logic [CFG_DATA_W-1:0] cnt);
    settle_out();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_WINDOW;
    cfg_wdata <= win;
    sb.write_reg(CFG_IDX_WINDOW, win);
    @(negedge clk_i);
    cfg_idx   <= CFG_IDX_TIMEOUT;
    cfg_wdata <= tmo;
    sb.write_reg(CFG_IDX_TIMEOUT, tmo);
    @(negedge clk_i);
    cfg_idx   <= CFG_IDX_COUNT;
    cfg_wdata <= cnt;
    sb.write_reg(CFG_IDX_COUNT, cnt);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly ticks; acks mostly hit outstanding packets, the rest land anywhere
  task automatic run_phase(int unsigned n_items, int unsigned ack_pct);
    logic [SEQ_W-1:0] a;
    bit               m;
    repeat (n_items) begin
      a = SEQ_W'($urandom_range(SEQ_N-1));
      m = MODE_TICK;
      if ($urandom_range(99) < ack_pct) begin
        m = MODE_ACK;
        if ($urandom_range(3) != 0) void'(sb.find_outstanding(a));
      end
      if ($urandom_range(59) == 0) settle_out();
      send_event(m, a);
    end
  endtask

  initial begin
    sb            = new();
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_TICK;
    in_ch.ack_seq = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first item after reset opens the first window
    send_event(MODE_TICK, 6'h15);
    send_event(MODE_ACK, 6'h3F);   // beyond the packet count
    send_event(MODE_ACK, 6'd2);    // out of order
    send_event(MODE_ACK, 6'd0);
    send_event(MODE_ACK, 6'd7);    // never sent
    send_event(MODE_ACK, 6'd2);    // already acknowledged
    send_event(MODE_TICK, 6'h2A);
    send_event(MODE_TICK, 6'h00);
    send_event(MODE_TICK, 6'h3F);
    send_event(MODE_ACK, 6'd1);

    // zero timeout resends every running timer
    set_config(8'd4, 8'd0, 8'd10);
    send_event(MODE_TICK, 6'h0F);
    send_event(MODE_ACK, 6'd5);

    // window of zero behaves as one
    set_config(8'd0, 8'd255, 8'd10);
    send_event(MODE_TICK, 6'h30);
    send_event(MODE_ACK, 6'd9);

    // empty packet count
    set_config(8'd31, 8'd255, 8'd0);
    send_event(MODE_TICK, 6'h11);
    send_event(MODE_ACK, 6'd0);

    // oversized window and count saturate
    set_config(8'd31, 8'd255, 8'd127);
    send_event(MODE_TICK, 6'h22);
    send_event(MODE_ACK, 6'd63);

    // count lowered below the base
    set_config(8'd31, 8'd255, CFG_DATA_W'((sb.base > 0) ? sb.base - 1 : 0));
    send_event(MODE_TICK, 6'h0C);
    send_event(MODE_ACK, 6'd1);

    // a long stretch with no idling on either side
    set_config(8'd2, 8'd3, CFG_DATA_W'(sb.base + 4));
    quiet = 1'b1;
    run_phase(40, 25);
    quiet = 1'b0;

    set_config(8'd1, 8'd1, CFG_DATA_W'(sb.base + 6));
    run_phase(70, 20);
    set_config(8'd16, 8'd2, CFG_DATA_W'(sb.base + 20));
    run_phase(70, 15);
    set_config(8'd5, 8'd0, CFG_DATA_W'(sb.base + 12));
    run_phase(60, 15);
    set_config(8'd31, 8'd200, CFG_DATA_W'(sb.base + 16));
    run_phase(60, 20);
    set_config(8'd3, 8'd7, CFG_DATA_W'(sb.base / 2));
    run_phase(20, 20);
    set_config(8'd16, 8'd4, 8'd127);
    run_phase(90, 15);

    settle_out();
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(50ms);
    $display("Mismatches found");
    $finish;
  end

endmodule
